// ----- sv/dnsqp_pkg.sv -----
package dnsqp_pkg;

  localparam logic [7:0] DOT_CHAR     = 8'h2E;
  localparam logic [7:0] MAX_NAME_RST = 8'd255;
  localparam logic [8:0] SEEN_SAT     = 9'h1FF;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_LEN    = 3'd2,
    PH_CHARS  = 3'd3,
    PH_QTYPE  = 3'd4,
    PH_QCLASS = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    KIND_ID        = 4'd0,
    KIND_FLAGS     = 4'd1,
    KIND_QD        = 4'd2,
    KIND_AN        = 4'd3,
    KIND_NS        = 4'd4,
    KIND_AR        = 4'd5,
    KIND_NAME_CHAR = 4'd6,
    KIND_NAME_END  = 4'd7,
    KIND_QTYPE     = 4'd8,
    KIND_QCLASS    = 4'd9,
    KIND_NAME_ERR  = 4'd10
  } kind_e;

  localparam logic [2:0] HDR_WORD_QD = 3'd2;
  localparam logic [2:0] HDR_WORD_AR = 3'd5;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  word_idx;
    logic [7:0]  high_hold;
    logic        has_question;
    logic [7:0]  label_left;
    logic [8:0]  name_seen;
    logic        first_label;
  } parse_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic        done;
  } result_t;

endpackage

// ----- sv/dnsqp_step.sv -----
module dnsqp_step
  import dnsqp_pkg::*;
(
  input  parse_state_t state_i,
  input  logic [7:0]   byte_value_i,
  input  logic         packet_start_i,
  input  logic [7:0]   max_name_bytes_i,
  output parse_state_t state_o,
  output logic         emit_o,
  output result_t      result_o
);

  parse_state_t s;
  parse_state_t n;
  logic [8:0]   seen_inc;
  logic [15:0]  word;

  always_comb begin
    s = state_i;
    if (packet_start_i) begin
      s.phase        = PH_HEADER;
      s.word_idx     = 4'd0;
      s.high_hold    = 8'd0;
      s.has_question = 1'b0;
      s.label_left   = 8'd0;
      s.name_seen    = 9'd0;
      s.first_label  = 1'b1;
    end

    n        = s;
    emit_o   = 1'b0;
    result_o = '{kind: KIND_ID, value: 16'd0, done: 1'b0};
    seen_inc = (s.name_seen != SEEN_SAT) ? s.name_seen + 9'd1 : s.name_seen;
    word     = {s.high_hold, byte_value_i};

    unique case (s.phase)
      PH_HEADER: begin
        if (!s.word_idx[0]) begin
          n.high_hold = byte_value_i;
          n.word_idx  = s.word_idx + 4'd1;
        end else begin
          emit_o         = 1'b1;
          result_o.kind  = kind_e'({1'b0, s.word_idx[3:1]});
          result_o.value = word;
          if (s.word_idx[3:1] == HDR_WORD_QD) begin
            n.has_question = (word != 16'd0);
          end
          if (s.word_idx[3:1] == HDR_WORD_AR) begin
            n.word_idx    = 4'd0;
            n.phase       = s.has_question ? PH_LEN : PH_DONE;
            result_o.done = !s.has_question;
          end else begin
            n.word_idx = s.word_idx + 4'd1;
          end
        end
      end

      PH_LEN, PH_CHARS: begin
        n.name_seen = seen_inc;
        if (seen_inc > {1'b0, max_name_bytes_i}) begin
          n.phase       = PH_DONE;
          emit_o        = 1'b1;
          result_o.kind = KIND_NAME_ERR;
          result_o.done = 1'b1;
        end else if (s.phase == PH_CHARS) begin
          n.label_left = s.label_left - 8'd1;
          if (s.label_left == 8'd1) begin
            n.phase = PH_LEN;
          end
          emit_o         = 1'b1;
          result_o.kind  = KIND_NAME_CHAR;
          result_o.value = {8'd0, byte_value_i};
        end else if (byte_value_i == 8'd0) begin
          n.phase       = PH_QTYPE;
          n.word_idx    = 4'd0;
          emit_o        = 1'b1;
          result_o.kind = KIND_NAME_END;
        end else begin
          n.label_left = byte_value_i;
          n.phase      = PH_CHARS;
          if (s.first_label) begin
            n.first_label = 1'b0;
          end else begin
            emit_o         = 1'b1;
            result_o.kind  = KIND_NAME_CHAR;
            result_o.value = {8'd0, DOT_CHAR};
          end
        end
      end

      PH_QTYPE, PH_QCLASS: begin
        if (s.word_idx == 4'd0) begin
          n.high_hold = byte_value_i;
          n.word_idx  = 4'd1;
        end else begin
          n.word_idx     = 4'd0;
          emit_o         = 1'b1;
          result_o.value = word;
          if (s.phase == PH_QTYPE) begin
            n.phase       = PH_QCLASS;
            result_o.kind = KIND_QTYPE;
          end else begin
            n.phase       = PH_DONE;
            result_o.kind = KIND_QCLASS;
            result_o.done = 1'b1;
          end
        end
      end

      default: begin
      end
    endcase

    state_o = n;
  end

endmodule

// ----- sv/dnsqp_outbuf.sv -----
module dnsqp_outbuf
  import dnsqp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    out_vld_q;
  logic    skid_vld_q;
  result_t out_q;
  result_t skid_q;
  logic    pop;

  assign pop         = out_vld_q && out_ready_i;
  assign ready_o     = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign result_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= push_i;
      end else begin
        out_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q  <= skid_q;
        skid_q <= result_i;
      end else begin
        out_q <= result_i;
      end
    end else if (push_i) begin
      skid_q <= result_i;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output slot");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && out_vld_q && !pop |=> skid_vld_q)
    else $error("request lost while output stalled");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !skid_vld_q && !push_i |=> !out_vld_q)
    else $error("output valid without a pending request");

endmodule

// ----- sv/dns_query_header_parser.sv -----
// Each accepted byte updates the registered parse state; its result goes to the
// output slot, or to the skid entry while the output stalls. One byte per cycle
// is taken while input ready is high. A two-entry output buffer keeps input
// ready high while one result waits; ready drops only when two results are held.
// Reset (async, active low) sets the parser idle until a packet start,
// max_name_bytes to 255, and empties the output buffer.
module dns_query_header_parser
  import dnsqp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  result_kind_o,
  output logic [15:0] result_value_o,
  output logic        message_done_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i
);

  parse_state_t state_q;
  parse_state_t state_d;
  logic [7:0]   max_name_q;
  logic         emit;
  logic         accept;
  result_t      step_res;
  result_t      out_res;

  assign accept = in_valid_i && in_ready_o;

  dnsqp_step u_step (
    .state_i          (state_q),
    .byte_value_i     (byte_value_i),
    .packet_start_i   (packet_start_i),
    .max_name_bytes_i (max_name_q),
    .state_o          (state_d),
    .emit_o           (emit),
    .result_o         (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '{phase: PH_IDLE, word_idx: 4'd0, high_hold: 8'd0,
                      has_question: 1'b0, label_left: 8'd0, name_seen: 9'd0,
                      first_label: 1'b1};
      max_name_q <= MAX_NAME_RST;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        max_name_q <= cfg_data_i;
      end
    end
  end

  dnsqp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .result_i    (step_res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign result_value_o = out_res.value;
  assign message_done_o = out_res.done;

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |->
      (result_kind_o == KIND_AR) || (result_kind_o == KIND_QCLASS) ||
      (result_kind_o == KIND_NAME_ERR))
    else $error("message end flagged on a non-final result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_NAME_ERR) |->
      (result_value_o == 16'd0) && message_done_o)
    else $error("name error with nonzero value or open message");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != PH_IDLE |=> state_q.phase != PH_IDLE)
    else $error("parser returned to idle without reset");

endmodule

// ----- sim/tb_dns_query_header_parser.sv -----
module tb_dns_query_header_parser;
  import dnsqp_pkg::*;

  typedef struct packed {
    logic       st;
    logic [7:0] b;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'h00;
  logic        packet_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  result_kind;
  logic [15:0] result_value;
  logic        message_done;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  phase_e      phase;
  logic [3:0]  word_idx;
  logic [7:0]  high_hold;
  logic        has_q;
  logic [7:0]  label_left;
  logic [8:0]  name_seen;
  logic        first_label;
  logic [7:0]  name_limit;

  result_t     pending_results[$];
  request_t    msg_q[$];
  int          mismatches = 0;
  int          parsed_bytes = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;

  dns_query_header_parser dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .byte_value_i  (byte_value),
    .packet_start_i(packet_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind),
    .result_value_o(result_value),
    .message_done_o(message_done),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_parse();
    phase = PH_IDLE;
    word_idx = '0;
    high_hold = '0;
    has_q = 1'b0;
    label_left = '0;
    name_seen = '0;
    first_label = 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic st, output result_t res);
    logic [15:0] word;
    logic [2:0]  widx;
    res = '0;
    if (st) begin
      clear_parse();
      phase = PH_HEADER;
    end
    if (phase != PH_IDLE && phase != PH_DONE) parsed_bytes++;
    case (phase)
      PH_HEADER: begin
        if (!word_idx[0]) begin
          high_hold = b;
          word_idx++;
          return 1'b0;
        end
        word = {high_hold, b};
        widx = word_idx[3:1];
        res.kind = kind_e'({1'b0, widx});
        res.value = word;
        if (widx == HDR_WORD_QD) has_q = (word != 16'h0000);
        if (widx == HDR_WORD_AR) begin
          word_idx = '0;
          phase = has_q ? PH_LEN : PH_DONE;
          res.done = !has_q;
          return 1'b1;
        end
        word_idx++;
        return 1'b1;
      end
      PH_LEN, PH_CHARS: begin
        if (name_seen < SEEN_SAT) name_seen++;
        if (name_seen > {1'b0, name_limit}) begin
          phase = PH_DONE;
          res.kind = KIND_NAME_ERR;
          res.done = 1'b1;
          return 1'b1;
        end
        if (phase == PH_CHARS) begin
          label_left--;
          if (label_left == 8'h00) phase = PH_LEN;
          res.kind = KIND_NAME_CHAR;
          res.value = {8'h00, b};
          return 1'b1;
        end
        if (b == 8'h00) begin
          phase = PH_QTYPE;
          word_idx = '0;
          res.kind = KIND_NAME_END;
          return 1'b1;
        end
        label_left = b;
        phase = PH_CHARS;
        if (first_label) begin
          first_label = 1'b0;
          return 1'b0;
        end
        res.kind = KIND_NAME_CHAR;
        res.value = {8'h00, DOT_CHAR};
        return 1'b1;
      end
      PH_QTYPE, PH_QCLASS: begin
        if (word_idx == 4'd0) begin
          high_hold = b;
          word_idx = 4'd1;
          return 1'b0;
        end
        res.value = {high_hold, b};
        word_idx = '0;
        if (phase == PH_QTYPE) begin
          phase = PH_QCLASS;
          res.kind = KIND_QTYPE;
          return 1'b1;
        end
        phase = PH_DONE;
        res.kind = KIND_QCLASS;
        res.done = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_request(input logic [7:0] b, input logic st);
    result_t res;
    int      gap;
    @(negedge clk);
    in_valid <= 1'b1;
    byte_value <= b;
    packet_start <= st;
    do @(posedge clk); while (!in_ready);
    if (parse_byte(b, st, res)) pending_results.push_back(res);
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_name(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    name_limit = v;
  endtask

  function automatic void push_byte(input logic [7:0] b);
    request_t r;
    r.st = 1'b0;
    r.b = b;
    msg_q.push_back(r);
  endfunction

  function automatic void push_word(input logic [15:0] w);
    push_byte(w[15:8]);
    push_byte(w[7:0]);
  endfunction

  function automatic void push_header(input logic [15:0] id, input logic [15:0] flags,
                                      input logic [15:0] qd, input logic [15:0] an,
                                      input logic [15:0] ns, input logic [15:0] ar);
    request_t r;
    r.st = 1'b1;
    r.b = id[15:8];
    msg_q.push_back(r);
    push_byte(id[7:0]);
    push_word(flags);
    push_word(qd);
    push_word(an);
    push_word(ns);
    push_word(ar);
  endfunction

  task automatic send_msg();
    foreach (msg_q[i]) send_request(msg_q[i].b, msg_q[i].st);
    msg_q.delete();
  endtask

  function automatic void build_random_message();
    int          labels;
    int          len;
    int          r;
    logic [15:0] qd;
    r = $urandom_range(0, 99);
    qd = (r < 20) ? 16'h0000 : 16'($urandom_range(1, 65535));
    push_header(16'($urandom), 16'($urandom), qd, 16'($urandom), 16'($urandom),
                16'($urandom));
    if (qd != 16'h0000) begin
      labels = $urandom_range(0, 4);
      repeat (labels) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 10);
        else if (r < 95) len = $urandom_range(11, 63);
        else len = $urandom_range(64, 255);
        push_byte(8'(len));
        repeat (len) push_byte(8'($urandom));
      end
      push_byte(8'h00);
      push_word(16'($urandom));
      push_word(16'($urandom));
    end
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
    if ($urandom_range(0, 99) < 12) msg_q = msg_q[0:$urandom_range(0, msg_q.size() - 1)];
    if ($urandom_range(0, 99) < 5) repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (receiver_steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d value %0h done %0b",
               result_kind, result_value, message_done);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
          mismatches++;
        end
        if (result_value !== want.value) begin
          $error("result_value: expected %0h, got %0h", want.value, result_value);
          mismatches++;
        end
        if (message_done !== want.done) begin
          $error("message_done: expected %0b, got %0b", want.done, message_done);
          mismatches++;
        end
      end
    end
  end

  task automatic test_before_start();
    push_byte(8'hFF);
    push_byte(8'h00);
    send_msg();
    wait_for_results();
  endtask

  task automatic test_header_only();
    push_header(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE);
    push_byte(8'hAB);
    send_msg();
    wait_for_results();
  endtask

  task automatic test_restart_empty_name();
    push_header(16'h1234, 16'h5678, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    msg_q = msg_q[0:4];
    push_header(16'h0000, 16'hFFFF, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    push_byte(8'h00);
    push_word(16'hFFFF);
    push_word(16'h0000);
    send_msg();
    wait_for_results();
  endtask

  task automatic test_name_limit();
    write_max_name(8'd1);
    push_header(16'h0001, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    push_byte(8'h03);
    push_byte(8'h61);
    push_byte(8'h62);
    send_msg();
    wait_for_results();
    write_max_name(8'd0);
    push_header(16'h0002, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    push_byte(8'h01);
    push_byte(8'h78);
    send_msg();
    wait_for_results();
    write_max_name(8'd255);
  endtask

  task automatic test_wide_labels();
    push_header(16'h0003, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    push_byte(8'h40);
    repeat (64) push_byte(8'($urandom));
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_word(16'h0001);
    push_word(16'h0001);
    send_msg();
    wait_for_results();
  endtask

  task automatic test_backpressure();
    hold_left = 120;
    sender_steady = 1'b1;
    repeat (3) begin
      build_random_message();
      send_msg();
    end
    sender_steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_messages();
    logic [7:0] limits[6];
    int         goal;
    limits[0] = 8'd255;
    limits[1] = 8'd1;
    limits[2] = 8'd0;
    limits[3] = 8'($urandom_range(2, 30));
    limits[4] = 8'($urandom_range(31, 254));
    limits[5] = 8'd255;
    for (int i = 0; i < 6; i++) begin
      write_max_name(limits[i]);
      sender_steady = (i == 0);
      receiver_steady = (i == 0);
      goal = parsed_bytes + 100;
      while (parsed_bytes < goal) begin
        build_random_message();
        send_msg();
      end
      wait_for_results();
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    clear_parse();
    name_limit = MAX_NAME_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_before_start();
    test_header_only();
    test_restart_empty_name();
    test_name_limit();
    test_wide_labels();
    test_backpressure();
    test_random_messages();
    wait_for_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- dns_query_header_parser.f -----
sv/dnsqp_pkg.sv
sv/dnsqp_step.sv
sv/dnsqp_outbuf.sv
sv/dns_query_header_parser.sv
sim/tb_dns_query_header_parser.sv
